@@ sv/marching_squares_contour_cell_top_defines.svh @@
// Assertion macros for the marching squares contour cell block.
// Included by the top level; the macros expand to nothing under synthesis.
`ifndef MARCHING_SQUARES_CONTOUR_CELL_TOP_DEFINES_SVH
`define MARCHING_SQUARES_CONTOUR_CELL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MSC_ASSERT_IMPLIES(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("contour cell check failed");
`define MSC_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("contour cell check failed");
`else
`define MSC_ASSERT_IMPLIES(label, clock, reset_n, ante, cons)
`define MSC_ASSERT_NEXT(label, clock, reset_n, ante, cons)
`endif

`endif

@@ sv/msc_pkg.sv @@
// Shared types, widths and case tables of the marching squares contour cell.
// Used by msc_emit and marching_squares_contour_cell_top.
`default_nettype none

package msc_pkg;

    localparam int X_W    = 19;
    localparam int H_W    = 16;
    localparam int C_W    = 16;
    localparam int SIZE_W = 11;
    localparam int MUL_W  = 13;
    localparam int CODE_W = 4;
    localparam int K_W    = 3;
    localparam int CNT_W  = 4;
    localparam int PT_W   = 3;
    localparam int NUM_OFS = 5;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_MIN = 11'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1;

    localparam logic [ADDR_W-3:0] REG_CELL_SIZE = 1'b0;

    localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;
    localparam logic [CODE_W-1:0] CODE_ALL  = 4'd15;

    localparam logic [PT_W-1:0] P_AB  = 3'd0;
    localparam logic [PT_W-1:0] P_BC  = 3'd1;
    localparam logic [PT_W-1:0] P_CD  = 3'd2;
    localparam logic [PT_W-1:0] P_DA  = 3'd3;
    localparam logic [PT_W-1:0] P_BD  = 3'd4;
    localparam logic [PT_W-1:0] P_BBD = 3'd5;
    localparam logic [PT_W-1:0] P_DBD = 3'd6;

    localparam logic [CNT_W-1:0] CASE_COUNT [16] = '{
        4'd0, 4'd4, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd2,
        4'd2, 4'd4, 4'd8, 4'd4, 4'd4, 4'd2, 4'd4, 4'd0
    };

    localparam logic [PT_W-1:0] CASE_PTS [16][8] = '{
        '{P_AB, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB},
        '{P_CD, P_DBD, P_DBD, P_DA, P_AB, P_AB, P_AB, P_AB},
        '{P_BC, P_CD, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB},
        '{P_BC, P_BD, P_BD, P_DA, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_BBD, P_BBD, P_BC, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_DA, P_BC, P_CD, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_BD, P_BD, P_CD, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_DA, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_DA, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_BD, P_BD, P_CD, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_BBD, P_BBD, P_BC, P_CD, P_DBD, P_DBD, P_DA},
        '{P_AB, P_BBD, P_BBD, P_BC, P_AB, P_AB, P_AB, P_AB},
        '{P_BC, P_BD, P_BD, P_DA, P_AB, P_AB, P_AB, P_AB},
        '{P_BC, P_CD, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB},
        '{P_CD, P_DBD, P_DBD, P_DA, P_AB, P_AB, P_AB, P_AB},
        '{P_AB, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB, P_AB}
    };

    typedef struct packed {
        logic [NUM_OFS-1:0][X_W-1:0] xv;
        logic [NUM_OFS-1:0][X_W-1:0] zv;
        logic [CODE_W-1:0]           code;
        logic [H_W-1:0]              level;
    } cell_t;

    function automatic logic [PT_W-1:0] pt_dx(input logic [PT_W-1:0] p);
        logic [PT_W-1:0] r;
        case (p)
            P_AB:    r = 3'd2;
            P_BC:    r = 3'd4;
            P_CD:    r = 3'd2;
            P_DA:    r = 3'd0;
            P_BD:    r = 3'd2;
            P_BBD:   r = 3'd3;
            P_DBD:   r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [PT_W-1:0] pt_dz(input logic [PT_W-1:0] p);
        logic [PT_W-1:0] r;
        case (p)
            P_AB:    r = 3'd0;
            P_BC:    r = 3'd2;
            P_CD:    r = 3'd4;
            P_DA:    r = 3'd2;
            P_BD:    r = 3'd2;
            P_BBD:   r = 3'd1;
            P_DBD:   r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/msc_emit.sv @@
// Point serializer and output register of the contour cell block.
// Depends on msc_pkg for the cell record and the case tables.
`default_nettype none

module msc_emit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cell_valid,
    input  wire msc_pkg::cell_t            cell_in,
    output logic                           cell_take,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [msc_pkg::X_W-1:0] point_x,
    output logic signed [msc_pkg::X_W-1:0] point_z,
    output logic signed [msc_pkg::H_W-1:0] point_y,
    output logic                           last_point
);
    import msc_pkg::*;

    logic              ser_valid_reg;
    logic              ser_valid_next;
    cell_t             ser_cell_reg;
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [X_W-1:0]    px_reg;
    logic [X_W-1:0]    pz_reg;
    logic [H_W-1:0]    py_reg;
    logic              last_reg;

    logic              out_load;
    logic              is_last;
    logic [CNT_W-1:0]  n_pts;
    logic [PT_W-1:0]   pt;
    logic [X_W-1:0]    px_next;
    logic [X_W-1:0]    pz_next;

    always_comb
    begin
        n_pts    = CASE_COUNT[ser_cell_reg.code];
        pt       = CASE_PTS[ser_cell_reg.code][k_reg];
        px_next  = ser_cell_reg.xv[pt_dx(pt)];
        pz_next  = ser_cell_reg.zv[pt_dz(pt)];
        is_last  = ({1'b0, k_reg} == (n_pts - 4'd1));
        out_load = ser_valid_reg && (!out_valid_reg || !out_stall);
        cell_take = !ser_valid_reg || (out_load && is_last);

        ser_valid_next = ser_valid_reg;
        k_next         = k_reg;
        if (cell_take)
        begin
            ser_valid_next = cell_valid;
            k_next         = '0;
        end
        else if (out_load)
        begin
            k_next = k_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_take)
        begin
            ser_cell_reg <= cell_in;
        end
        if (out_load)
        begin
            px_reg   <= px_next;
            pz_reg   <= pz_next;
            py_reg   <= ser_cell_reg.level;
            last_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = $signed(px_reg);
    assign point_z    = $signed(pz_reg);
    assign point_y    = $signed(py_reg);
    assign last_point = last_reg;

endmodule

`default_nettype wire

@@ sv/marching_squares_contour_cell_top.sv @@
// Top level of the marching squares contour cell block: register port and
// compare/offset pipeline. Depends on msc_pkg, msc_emit and the defines header.
//
// Each input transfer carries one grid cell (top-left corner and four corner
// heights) and a contour level. The block classifies the corners against the
// level and emits 0, 2, 4 or 8 segment end points on the output channel, one
// transfer per cycle while out_stall is low, with last_point set on the final
// point of the cell. Cells whose corners all lie on one side produce no output.
// The cell_size register is written over the APB port at address 0; it is
// saturated to the range 1 to 1024 when used. pready is always high.
// An input transfer passes three pipeline stages, the point serializer and the
// output register before its first point appears at the output.
// The serializer holds a cell until all of its points are sent and takes the
// next cell as it loads the last point; empty cells never reach it.
// A stall at the output holds the current point; the pipeline keeps filling
// until every stage is occupied, then stalls the input.
// Reset clears all valid bits and sets cell_size to 1.
`default_nettype none

`include "marching_squares_contour_cell_top_defines.svh"

module marching_squares_contour_cell_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [msc_pkg::DATA_W-1:0]    pwdata,
    output logic      [msc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [msc_pkg::C_W-1:0] cell_x,
    input  wire logic signed [msc_pkg::C_W-1:0] cell_z,
    input  wire logic signed [msc_pkg::H_W-1:0] h_top_left,
    input  wire logic signed [msc_pkg::H_W-1:0] h_top_right,
    input  wire logic signed [msc_pkg::H_W-1:0] h_bottom_right,
    input  wire logic signed [msc_pkg::H_W-1:0] h_bottom_left,
    input  wire logic signed [msc_pkg::H_W-1:0] level,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [msc_pkg::X_W-1:0]     point_x,
    output logic signed [msc_pkg::X_W-1:0]     point_z,
    output logic signed [msc_pkg::H_W-1:0]     point_y,
    output logic                               last_point
);
    import msc_pkg::*;

    logic [SIZE_W-1:0] cell_size_reg;
    logic              cfg_write;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CODE_W-1:0] s1_code_reg;
    logic [CODE_W-1:0] s1_code_next;
    logic [X_W-1:0]    s1_bx_reg;
    logic [X_W-1:0]    s1_bz_reg;
    logic [SIZE_W-1:0] s1_s_reg;
    logic [SIZE_W-1:0] s1_s_next;
    logic [H_W-1:0]    s1_level_reg;

    logic                         s2_valid_reg;
    logic [CODE_W-1:0]            s2_code_reg;
    logic [X_W-1:0]               s2_bx_reg;
    logic [X_W-1:0]               s2_bz_reg;
    logic [NUM_OFS-1:0][MUL_W-1:0] s2_m_reg;
    logic [NUM_OFS-1:0][MUL_W-1:0] s2_m_next;
    logic [H_W-1:0]               s2_level_reg;

    logic  s3_valid_reg;
    cell_t s3_cell_reg;
    cell_t s3_cell_next;

    logic  en1;
    logic  en2;
    logic  en3;
    logic  in_accept;
    logic  cell_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[ADDR_W-1:2] == REG_CELL_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            cell_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_CELL_SIZE)
        begin
            prdata = {{(DATA_W-SIZE_W){1'b0}}, cell_size_reg};
        end
    end

    assign en3       = !s3_valid_reg || cell_take;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign in_stall  = !en1;
    assign in_accept = in_valid && en1;

    always_comb
    begin
        s1_code_next = {h_top_left > level, h_top_right > level,
                        h_bottom_right > level, h_bottom_left > level};
        s1_valid_next = in_accept && (s1_code_next != CODE_NONE)
                        && (s1_code_next != CODE_ALL);
        if (cell_size_reg < SIZE_MIN)
        begin
            s1_s_next = SIZE_MIN;
        end
        else if (cell_size_reg > SIZE_MAX)
        begin
            s1_s_next = SIZE_MAX;
        end
        else
        begin
            s1_s_next = cell_size_reg;
        end
    end

    always_comb
    begin
        s2_m_next[0] = '0;
        s2_m_next[1] = {2'b00, s1_s_reg};
        s2_m_next[2] = {1'b0, s1_s_reg, 1'b0};
        s2_m_next[3] = {2'b00, s1_s_reg} + {1'b0, s1_s_reg, 1'b0};
        s2_m_next[4] = {s1_s_reg, 2'b00};
    end

    always_comb
    begin
        for (int i = 0; i < NUM_OFS; i++)
        begin
            s3_cell_next.xv[i] = s2_bx_reg + {{(X_W-MUL_W){1'b0}}, s2_m_reg[i]};
            s3_cell_next.zv[i] = s2_bz_reg + {{(X_W-MUL_W){1'b0}}, s2_m_reg[i]};
        end
        s3_cell_next.code  = s2_code_reg;
        s3_cell_next.level = s2_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_code_reg  <= s1_code_next;
            s1_bx_reg    <= {cell_x[C_W-1], cell_x, 2'b00};
            s1_bz_reg    <= {cell_z[C_W-1], cell_z, 2'b00};
            s1_s_reg     <= s1_s_next;
            s1_level_reg <= level;
        end
        if (en2)
        begin
            s2_code_reg  <= s1_code_reg;
            s2_bx_reg    <= s1_bx_reg;
            s2_bz_reg    <= s1_bz_reg;
            s2_m_reg     <= s2_m_next;
            s2_level_reg <= s1_level_reg;
        end
        if (en3)
        begin
            s3_cell_reg <= s3_cell_next;
        end
    end

    msc_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (s3_valid_reg),
        .cell_in    (s3_cell_reg),
        .cell_take  (cell_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_z    (point_z),
        .point_y    (point_y),
        .last_point (last_point)
    );

    `MSC_ASSERT_IMPLIES(a_s1_code_has_points, clk, rst_n, s1_valid_reg,
                        (s1_code_reg != CODE_NONE) && (s1_code_reg != CODE_ALL))
    `MSC_ASSERT_IMPLIES(a_s1_size_in_range, clk, rst_n, s1_valid_reg,
                        (s1_s_reg >= SIZE_MIN) && (s1_s_reg <= SIZE_MAX))
    `MSC_ASSERT_NEXT(a_s3_held_on_stall, clk, rst_n, s3_valid_reg && !cell_take,
                     s3_valid_reg && $stable(s3_cell_reg))

endmodule

`default_nettype wire

@@ test/tb_marching_squares_contour_cell_top.sv @@
// Self-checking testbench for marching_squares_contour_cell_top: cells go in, predicted
// segment end points are compared with every output transfer, across several cell sizes.
// Depends on msc_pkg and the top level RTL only.
`timescale 1ns / 100ps

module tb_marching_squares_contour_cell_top;

    import msc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 250;
    localparam int STALL_LIMIT  = 2000;
    localparam int NUM_SIZES    = 8;

    localparam logic [ADDR_W-1:0] ADDR_CELL_SIZE = {REG_CELL_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNUSED    = {~REG_CELL_SIZE, 2'b00};

    typedef enum logic [2:0] {
        PT_AB, PT_BC, PT_CD, PT_DA, PT_CTR, PT_QTR_B, PT_QTR_D
    } seg_pt_t;

    // Offsets of each point from the top-left corner, in quarters of the cell size.
    localparam int QDX [7] = '{2, 4, 2, 0, 2, 3, 1};
    localparam int QDZ [7] = '{0, 2, 4, 2, 2, 1, 3};

    localparam int SEG_COUNT [16] = '{0, 4, 2, 4, 4, 4, 4, 2, 2, 4, 8, 4, 4, 2, 4, 0};

    localparam seg_pt_t SEG_PTS [16][8] = '{
        '{PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_CD, PT_QTR_D, PT_QTR_D, PT_DA, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_BC, PT_CD, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_BC, PT_CTR, PT_CTR, PT_DA, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_QTR_B, PT_QTR_B, PT_BC, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_DA, PT_BC, PT_CD, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_CTR, PT_CTR, PT_CD, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_DA, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_DA, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_CTR, PT_CTR, PT_CD, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_QTR_B, PT_QTR_B, PT_BC, PT_CD, PT_QTR_D, PT_QTR_D, PT_DA},
        '{PT_AB, PT_QTR_B, PT_QTR_B, PT_BC, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_BC, PT_CTR, PT_CTR, PT_DA, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_BC, PT_CD, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_CD, PT_QTR_D, PT_QTR_D, PT_DA, PT_AB, PT_AB, PT_AB, PT_AB},
        '{PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB, PT_AB}
    };

    typedef struct packed {
        logic [C_W-1:0] cx;
        logic [C_W-1:0] cz;
        logic [H_W-1:0] tl;
        logic [H_W-1:0] tr;
        logic [H_W-1:0] br;
        logic [H_W-1:0] bl;
        logic [H_W-1:0] lvl;
    } grid_cell_t;

    typedef struct packed {
        logic [X_W-1:0] px;
        logic [X_W-1:0] pz;
        logic [H_W-1:0] py;
        logic           last;
    } contour_point_t;

    logic                      clk;
    logic                      rst_n          = 1'b0;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [ADDR_W-1:0]         paddr          = '0;
    logic [DATA_W-1:0]         pwdata         = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid       = 1'b0;
    logic                      in_stall;
    logic signed [C_W-1:0]     cell_x         = '0;
    logic signed [C_W-1:0]     cell_z         = '0;
    logic signed [H_W-1:0]     h_top_left     = '0;
    logic signed [H_W-1:0]     h_top_right    = '0;
    logic signed [H_W-1:0]     h_bottom_right = '0;
    logic signed [H_W-1:0]     h_bottom_left  = '0;
    logic signed [H_W-1:0]     level          = '0;
    logic                      out_valid;
    logic                      out_stall      = 1'b0;
    logic signed [X_W-1:0]     point_x;
    logic signed [X_W-1:0]     point_z;
    logic signed [H_W-1:0]     point_y;
    logic                      last_point;

    grid_cell_t     pending_cells [$];
    contour_point_t expected_points [$];
    grid_cell_t     cur_cell;
    logic [SIZE_W-1:0] cell_size_cfg = SIZE_RESET;
    logic [15:0]    codes_seen       = '0;
    logic           idle_on          = 1'b1;
    logic           hold_req         = 1'b0;
    logic           run_done         = 1'b0;
    int             hold_left        = 0;
    int             gap_left         = 0;
    int             stall_left       = 0;
    int             quiet_cycles     = 0;
    int             cells_sent       = 0;
    int             points_checked   = 0;
    int             error_count      = 0;

    marching_squares_contour_cell_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_x         (cell_x),
        .cell_z         (cell_z),
        .h_top_left     (h_top_left),
        .h_top_right    (h_top_right),
        .h_bottom_right (h_bottom_right),
        .h_bottom_left  (h_bottom_left),
        .level          (level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .point_x        (point_x),
        .point_z        (point_z),
        .point_y        (point_y),
        .last_point     (last_point)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    function automatic void predict_segment_points(input grid_cell_t c);
        logic [3:0]     code;
        int             size;
        int             n;
        int             px;
        int             pz;
        seg_pt_t        p;
        contour_point_t e;
        size = int'(cell_size_cfg);
        if (size < int'(SIZE_MIN))
            size = int'(SIZE_MIN);
        if (size > int'(SIZE_MAX))
            size = int'(SIZE_MAX);
        code = {$signed(c.tl) > $signed(c.lvl), $signed(c.tr) > $signed(c.lvl),
                $signed(c.br) > $signed(c.lvl), $signed(c.bl) > $signed(c.lvl)};
        codes_seen[code] = 1'b1;
        n = SEG_COUNT[code];
        for (int k = 0; k < n; k++)
        begin
            p = SEG_PTS[code][k];
            px = 4 * $signed(c.cx) + QDX[p] * size;
            pz = 4 * $signed(c.cz) + QDZ[p] * size;
            e.px = px[X_W-1:0];
            e.pz = pz[X_W-1:0];
            e.py = c.lvl;
            e.last = (k == n - 1);
            expected_points = {expected_points, e};
        end
    endfunction

    function automatic grid_cell_t make_cell(input int cx, input int cz, input int tl,
                                             input int tr, input int br, input int bl,
                                             input int lvl);
        grid_cell_t c;
        c.cx = cx[C_W-1:0];
        c.cz = cz[C_W-1:0];
        c.tl = tl[H_W-1:0];
        c.tr = tr[H_W-1:0];
        c.br = br[H_W-1:0];
        c.bl = bl[H_W-1:0];
        c.lvl = lvl[H_W-1:0];
        return c;
    endfunction

    function automatic int near_level(input int lvl);
        int v;
        v = lvl + $urandom_range(0, 6) - 3;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    function automatic int corner_pick(input int lvl);
        int unsigned sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            return -32768;
        else if (sel == 1)
            return 32767;
        return lvl;
    endfunction

    function automatic grid_cell_t random_cell();
        int          lvl;
        int          cx;
        int          cz;
        int unsigned mode;
        grid_cell_t  c;
        lvl = $signed(16'($urandom));
        cx = $signed(16'($urandom));
        cz = $signed(16'($urandom));
        if ($urandom_range(0, 7) == 0)
            cx = $urandom_range(0, 1) ? 32767 : -32768;
        if ($urandom_range(0, 7) == 0)
            cz = $urandom_range(0, 1) ? 32767 : -32768;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            c = make_cell(cx, cz, near_level(lvl), near_level(lvl), near_level(lvl),
                          near_level(lvl), lvl);
        else if (mode < 8)
            c = make_cell(cx, cz, $signed(16'($urandom)), $signed(16'($urandom)),
                          $signed(16'($urandom)), $signed(16'($urandom)), lvl);
        else
            c = make_cell(cx, cz, corner_pick(lvl), corner_pick(lvl), corner_pick(lvl),
                          corner_pick(lvl), lvl);
        return c;
    endfunction

    // Sender: one cell per transfer, with a random gap after each one while idle_on is set.
    always @(posedge clk or negedge rst_n)
    begin : cell_driver
        logic take;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            take = !in_valid || !in_stall;
            if (in_valid && !in_stall)
            begin
                predict_segment_points(cur_cell);
                cells_sent++;
                gap_left = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (take)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cells.size() != 0)
                begin
                    cur_cell = pending_cells.pop_front();
                    cell_x <= cur_cell.cx;
                    cell_z <= cur_cell.cz;
                    h_top_left <= cur_cell.tl;
                    h_top_right <= cur_cell.tr;
                    h_bottom_right <= cur_cell.br;
                    h_bottom_left <= cur_cell.bl;
                    level <= cur_cell.lvl;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each point transfer, stalls at random after it while idle_on is set, and stalls during a hold.
    always @(posedge clk or negedge rst_n)
    begin : point_monitor
        contour_point_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t ns: unexpected point transfer x %h z %h y %h last %b",
                             $time, point_x, point_z, point_y, last_point);
                    error_count++;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (point_x !== e.px)
                    begin
                        $display("%0t ns: point_x expected %h actual %h", $time, e.px, point_x);
                        error_count++;
                    end
                    if (point_z !== e.pz)
                    begin
                        $display("%0t ns: point_z expected %h actual %h", $time, e.pz, point_z);
                        error_count++;
                    end
                    if (point_y !== e.py)
                    begin
                        $display("%0t ns: point_y expected %h actual %h", $time, e.py, point_y);
                        error_count++;
                    end
                    if (last_point !== e.last)
                    begin
                        $display("%0t ns: last_point expected %b actual %b",
                                 $time, e.last, last_point);
                        error_count++;
                    end
                end
                points_checked++;
                stall_left = idle_on ? $urandom_range(0, 7) : 0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            out_stall <= (hold_left != 0) || (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !run_done)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAIL marching_squares_contour_cell_top");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[ADDR_W-1:2] == REG_CELL_SIZE)
            cell_size_cfg = data[SIZE_W-1:0];
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cells.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_random(input int count);
        repeat (count) pending_cells = {pending_cells, random_cell()};
    endtask

    initial
    begin : stimulus
        int          lvl;
        int          sizes [NUM_SIZES];
        logic [DATA_W-1:0] wdata;
        sizes = '{1024, 0, 2047, 1025, 2, 1, 700, 0};
        sizes[NUM_SIZES-1] = $urandom_range(1, 1024);

        // Every case code, with the corners that are not above the level tied to it.
        for (int code = 0; code < 16; code++)
        begin
            lvl = code * 4000 - 32000;
            pending_cells = {pending_cells, make_cell(
                (code % 2) ? 32767 : -32768, (code % 2) ? -32768 : 32767,
                lvl + code[3], lvl + code[2], lvl + code[1], lvl + code[0], lvl)};
        end
        pending_cells = {pending_cells,
                         make_cell(0, 0, 32767, 32767, 32767, 32767, 32767)};
        pending_cells = {pending_cells,
                         make_cell(-1, 1, -32767, -32767, -32767, -32767, -32768)};
        pending_cells = {pending_cells,
                         make_cell(32767, 32767, 32767, -32768, 32767, -32768, -32768)};
        pending_cells = {pending_cells,
                         make_cell(-32768, -32768, 32767, -32768, 32767, 32767, 32766)};
        pending_cells = {pending_cells, make_cell(5, -7, -1, 0, 1, 32767, 0)};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int ph = 0; ph < NUM_SIZES; ph++)
        begin
            wdata = ($urandom() & ~32'h7FF) | DATA_W'(sizes[ph]);
            apb_write(ADDR_CELL_SIZE, wdata);
            if (ph == 4)
                apb_write(ADDR_UNUSED, 32'(SIZE_MAX));
            idle_on = (ph != 0);
            load_random(32);
            if (ph == 0)
            begin
                @(negedge clk);
                hold_req = 1'b1;
                @(negedge clk);
                hold_req = 1'b0;
            end
            wait_drained();
            idle_on = (ph % 2 == 1);
            load_random(30);
            wait_drained();
        end

        run_done = 1'b1;
        error_count += expected_points.size();
        $display("Run covered %0d cells and %0d checked points over %0d cell size settings.",
                 cells_sent, points_checked, NUM_SIZES + 1);
        $display("Case codes reached: %b", codes_seen);
        if (error_count == 0)
            $display("PASS marching_squares_contour_cell_top");
        else
            $display("FAIL marching_squares_contour_cell_top");
        $finish;
    end

endmodule
